// ----- src/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// imh_pkg
// shared types, sizes and codes of the indexed min-heap
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int CAPACITY  = 512;
  localparam int NUM_ITEMS = 512;
  localparam int ITEM_W    = 9;
  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 10;
  localparam int SLOT_W    = 10;
  localparam int CHILD_W   = 11;
  localparam int STATUS_W  = 3;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_EXTRACT = 2'd1;
  localparam logic [1:0] ACT_CHANGE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

  typedef struct packed {
    logic [1:0]              action;
    logic [ITEM_W-1:0]       item;
    logic signed [KEY_W-1:0] key_value;
  } in_t;

  typedef struct packed {
    logic [ITEM_W-1:0]       out_item;
    logic signed [KEY_W-1:0] out_key;
    logic [COUNT_W-1:0]      count;
    logic [STATUS_W-1:0]     status;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_EXT_TOP, S_EXT_LAST, S_EXT_KEY,
    S_UP_RD, S_UP_PI, S_UP_CMP, S_DN_RD, S_DN_C1, S_DN_C2, S_DN_CMP,
    S_PLACE, S_DONE
  } state_t;

endpackage

// ----- src/imh_ram.sv -----
// ----------------------------------------------------------------------------
// imh_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/imh_engine.sv -----
// ----------------------------------------------------------------------------
// imh_engine
// heap sequencer: request decode, sift up and sift down over four rams
// ----------------------------------------------------------------------------
module imh_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  imh_pkg::in_t  req,
  output logic          res_valid,
  input  logic          res_ready,
  output imh_pkg::out_t res
);

  localparam int IW = imh_pkg::ITEM_W;
  localparam int KW = imh_pkg::KEY_W;
  localparam int CW = imh_pkg::COUNT_W;
  localparam int SW = imh_pkg::SLOT_W;
  localparam int AW = $clog2(imh_pkg::NUM_ITEMS);
  localparam int PW = $clog2(imh_pkg::CAPACITY);

  imh_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [1:0] act, act_next;
  logic [IW-1:0] req_item, req_item_next;
  logic signed [KW-1:0] req_key, req_key_next;
  logic [IW-1:0] mi, mi_next;
  logic signed [KW-1:0] mk, mk_next;
  logic [SW-1:0] s, s_next;
  logic [IW-1:0] ci1, ci1_next;
  logic signed [KW-1:0] k1, k1_next;
  logic down_after, down_after_next;
  logic [IW-1:0] r_item, r_item_next;
  logic signed [KW-1:0] r_key, r_key_next;
  logic [imh_pkg::STATUS_W-1:0] r_status, r_status_next;
  logic [AW-1:0] clr_addr, clr_addr_next;

  logic key_we, s2i_we, i2s_we, pres_we;
  logic [AW-1:0] key_waddr, key_raddr, i2s_waddr, i2s_raddr, pres_waddr, pres_raddr;
  logic [PW-1:0] s2i_waddr, s2i_raddr;
  logic [KW-1:0] key_wdata, key_rd;
  logic [IW-1:0] s2i_wdata, s2i_rd;
  logic [SW-1:0] i2s_wdata, i2s_rd;
  logic pres_wdata, pres_rd;

  logic [imh_pkg::CHILD_W-1:0] c;
  logic has_two, pick2;
  logic [IW-1:0] sel_item;
  logic signed [KW-1:0] sel_key;
  logic [SW-1:0] sel_slot;

  imh_ram #(.WIDTH(KW), .DEPTH(imh_pkg::NUM_ITEMS)) u_key (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata), .raddr(key_raddr),
    .rdata(key_rd));
  imh_ram #(.WIDTH(IW), .DEPTH(imh_pkg::CAPACITY)) u_s2i (
    .clk, .we(s2i_we), .waddr(s2i_waddr), .wdata(s2i_wdata), .raddr(s2i_raddr),
    .rdata(s2i_rd));
  imh_ram #(.WIDTH(SW), .DEPTH(imh_pkg::NUM_ITEMS)) u_i2s (
    .clk, .we(i2s_we), .waddr(i2s_waddr), .wdata(i2s_wdata), .raddr(i2s_raddr),
    .rdata(i2s_rd));
  imh_ram #(.WIDTH(1), .DEPTH(imh_pkg::NUM_ITEMS)) u_pres (
    .clk, .we(pres_we), .waddr(pres_waddr), .wdata(pres_wdata), .raddr(pres_raddr),
    .rdata(pres_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= imh_pkg::S_CLEAR;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      clr_addr <= clr_addr_next;
    end
    act        <= act_next;
    req_item   <= req_item_next;
    req_key    <= req_key_next;
    mi         <= mi_next;
    mk         <= mk_next;
    s          <= s_next;
    ci1        <= ci1_next;
    k1         <= k1_next;
    down_after <= down_after_next;
    r_item     <= r_item_next;
    r_key      <= r_key_next;
    r_status   <= r_status_next;
  end

  assign c        = {s, 1'b0};
  assign has_two  = c < imh_pkg::CHILD_W'(count);
  assign pick2    = has_two && ($signed(key_rd) < k1);
  assign sel_item = pick2 ? s2i_rd : ci1;
  assign sel_key  = pick2 ? $signed(key_rd) : k1;
  assign sel_slot = pick2 ? SW'(c + 1'b1) : SW'(c);

  assign req_ready = (state == imh_pkg::S_IDLE);
  assign res_valid = (state == imh_pkg::S_DONE);
  assign res       = '{out_item: r_item, out_key: r_key, count: count, status: r_status};

  always_comb begin
    state_next      = state;
    count_next      = count;
    clr_addr_next   = clr_addr;
    act_next        = act;
    req_item_next   = req_item;
    req_key_next    = req_key;
    mi_next         = mi;
    mk_next         = mk;
    s_next          = s;
    ci1_next        = ci1;
    k1_next         = k1;
    down_after_next = down_after;
    r_item_next     = r_item;
    r_key_next      = r_key;
    r_status_next   = r_status;
    key_we = 1'b0; key_waddr = req_item; key_wdata = req_key; key_raddr = '0;
    s2i_we = 1'b0; s2i_waddr = '0; s2i_wdata = mi; s2i_raddr = '0;
    i2s_we = 1'b0; i2s_waddr = mi; i2s_wdata = s; i2s_raddr = '0;
    pres_we = 1'b0; pres_waddr = req_item; pres_wdata = 1'b0; pres_raddr = '0;

    case (state)
      imh_pkg::S_CLEAR: begin
        pres_we       = 1'b1;
        pres_waddr    = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(imh_pkg::NUM_ITEMS - 1)) begin
          state_next = imh_pkg::S_IDLE;
        end
      end
      imh_pkg::S_IDLE: begin
        pres_raddr = req.item;
        i2s_raddr  = req.item;
        s2i_raddr  = '0;
        if (req_valid) begin
          act_next      = req.action;
          req_item_next = req.item;
          req_key_next  = req.key_value;
          r_item_next   = req.item;
          r_key_next    = req.key_value;
          r_status_next = imh_pkg::ST_OK;
          case (req.action)
            imh_pkg::ACT_INSERT, imh_pkg::ACT_CHANGE: state_next = imh_pkg::S_CHECK;
            imh_pkg::ACT_EXTRACT: begin
              if (count == '0) begin
                r_item_next   = '0;
                r_key_next    = '0;
                r_status_next = imh_pkg::ST_EMPTY;
                state_next    = imh_pkg::S_DONE;
              end else begin
                state_next = imh_pkg::S_EXT_TOP;
              end
            end
            default: begin
              r_item_next = '0;
              r_key_next  = '0;
              state_next  = imh_pkg::S_DONE;
            end
          endcase
        end
      end
      imh_pkg::S_CHECK: begin
        mi_next = req_item;
        mk_next = req_key;
        if (act == imh_pkg::ACT_INSERT) begin
          if (pres_rd) begin
            r_status_next = imh_pkg::ST_DUP;
            state_next    = imh_pkg::S_DONE;
          end else if (count == CW'(imh_pkg::CAPACITY)) begin
            r_status_next = imh_pkg::ST_FULL;
            state_next    = imh_pkg::S_DONE;
          end else begin
            count_next      = count + 1'b1;
            key_we          = 1'b1;
            pres_we         = 1'b1;
            pres_wdata      = 1'b1;
            s_next          = SW'(count + 1'b1);
            down_after_next = 1'b0;
            state_next      = imh_pkg::S_UP_RD;
          end
        end else begin
          if (!pres_rd) begin
            r_status_next = imh_pkg::ST_ABSENT;
            state_next    = imh_pkg::S_DONE;
          end else begin
            key_we          = 1'b1;
            s_next          = i2s_rd;
            down_after_next = 1'b1;
            state_next      = imh_pkg::S_UP_RD;
          end
        end
      end
      imh_pkg::S_EXT_TOP: begin
        r_item_next = s2i_rd;
        key_raddr   = s2i_rd;
        s2i_raddr   = PW'(count - 1'b1);
        pres_we     = 1'b1;
        pres_waddr  = s2i_rd;
        count_next  = count - 1'b1;
        state_next  = imh_pkg::S_EXT_LAST;
      end
      imh_pkg::S_EXT_LAST: begin
        r_key_next = $signed(key_rd);
        mi_next    = s2i_rd;
        key_raddr  = s2i_rd;
        state_next = imh_pkg::S_EXT_KEY;
      end
      imh_pkg::S_EXT_KEY: begin
        mk_next    = $signed(key_rd);
        s_next     = SW'(1);
        state_next = imh_pkg::S_DN_RD;
      end
      imh_pkg::S_UP_RD: begin
        if (s == SW'(1)) begin
          state_next = down_after ? imh_pkg::S_DN_RD : imh_pkg::S_PLACE;
        end else begin
          s2i_raddr  = PW'(s[SW-1:1] - 1'b1);
          state_next = imh_pkg::S_UP_PI;
        end
      end
      imh_pkg::S_UP_PI: begin
        ci1_next   = s2i_rd;
        key_raddr  = s2i_rd;
        state_next = imh_pkg::S_UP_CMP;
      end
      imh_pkg::S_UP_CMP: begin
        if (mk < $signed(key_rd)) begin
          // parent moves down into the hole
          s2i_we     = 1'b1;
          s2i_waddr  = PW'(s - 1'b1);
          s2i_wdata  = ci1;
          i2s_we     = 1'b1;
          i2s_waddr  = ci1;
          i2s_wdata  = s;
          s_next     = {1'b0, s[SW-1:1]};
          state_next = imh_pkg::S_UP_RD;
        end else begin
          state_next = down_after ? imh_pkg::S_DN_RD : imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_DN_RD: begin
        if (c > imh_pkg::CHILD_W'(count)) begin
          state_next = imh_pkg::S_PLACE;
        end else begin
          s2i_raddr  = PW'(c - 1'b1);
          state_next = imh_pkg::S_DN_C1;
        end
      end
      imh_pkg::S_DN_C1: begin
        ci1_next   = s2i_rd;
        key_raddr  = s2i_rd;
        s2i_raddr  = PW'(c);
        state_next = imh_pkg::S_DN_C2;
      end
      imh_pkg::S_DN_C2: begin
        k1_next    = $signed(key_rd);
        key_raddr  = s2i_rd;
        s2i_raddr  = PW'(c);
        state_next = imh_pkg::S_DN_CMP;
      end
      imh_pkg::S_DN_CMP: begin
        // s2i_rd holds the right child item, read again in S_DN_C2
        if (sel_key < mk) begin
          s2i_we     = 1'b1;
          s2i_waddr  = PW'(s - 1'b1);
          s2i_wdata  = sel_item;
          i2s_we     = 1'b1;
          i2s_waddr  = sel_item;
          i2s_wdata  = s;
          s_next     = sel_slot;
          state_next = imh_pkg::S_DN_RD;
        end else begin
          state_next = imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_PLACE: begin
        s2i_we     = 1'b1;
        s2i_waddr  = PW'(s - 1'b1);
        i2s_we     = 1'b1;
        state_next = imh_pkg::S_DONE;
      end
      imh_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = imh_pkg::S_IDLE;
        end
      end
      default: state_next = imh_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- src/indexed_min_heap.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap
// indexed binary min-heap of item ids ordered by signed per-item keys
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  --------+----------------------------------+----------------------------------
//  request | in_valid, in_ready, in_data      | action, item, key_value
//  result  | out_valid, out_ready, out_data   | out_item, out_key, count, status
//
// one request at a time; insert climbs the heap level by level, extract descends it,
// change climbs and then descends; each level is bounded by one read port per ram
// reset starts a pass clearing the presence ram, in_ready stays low
// a held result does not block the next request; the one after waits for it
// ----------------------------------------------------------------------------
module indexed_min_heap (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  imh_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output imh_pkg::out_t out_data
);

  logic          res_valid;
  logic          res_ready;
  imh_pkg::out_t res;

  // sequencer with key, slot and presence rams
  imh_engine u_engine (
    .clk,
    .rst,
    .req_valid(in_valid),
    .req_ready(in_ready),
    .req(in_data),
    .res_valid,
    .res_ready,
    .res
  );

  // output register: engine hands over when the slot is free or draining
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// ----- src/imh_checker.sv -----
// ----------------------------------------------------------------------------
// imh_checker
// port-level checks of the indexed min-heap
// ----------------------------------------------------------------------------
module imh_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input imh_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input imh_pkg::out_t out_data
);

  // clearing pass holds off requests right after reset
  a_clear: assert property (@(posedge clk) $past(rst) && !rst |-> !in_ready)
    else $error("request taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == imh_pkg::ST_EMPTY |->
      out_data.count == '0 && out_data.out_item == '0 && out_data.out_key == '0)
    else $error("empty extract result not zero");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == imh_pkg::ST_FULL |->
      out_data.count == imh_pkg::COUNT_W'(imh_pkg::CAPACITY))
    else $error("full status below capacity");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.count <= imh_pkg::COUNT_W'(imh_pkg::CAPACITY))
    else $error("count above capacity");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
